### hw/rtl/sdrf_pkg.sv
package sdrf_pkg;

    localparam int W     = 32;           // word width of every Q value
    localparam int F     = 16;           // fraction bits
    localparam int DW    = W + 1;        // anchor offset, signed
    localparam int SQW   = 2 * DW + 2;   // radicand, even width
    localparam int RTW   = SQW / 2;      // root width
    localparam int QW    = F + 1;        // direction quotient magnitude
    localparam int NW    = F + 2;        // signed direction component
    localparam int PW    = 2 * W + 2;    // full product of two W+1 bit magnitudes
    localparam int VNW   = W + NW + 2;   // sum of three velocity products
    localparam int LANES = 3;
    localparam int CFG_IW = 3;

    localparam logic [RTW-1:0] DIST_EPS = RTW'(((1 << F) + 999) / 1000);
    localparam logic [W-2:0]   GAIN_RST = (W-1)'(117965);
    localparam logic [W-1:0]   SMAX     = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   SMIN     = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [CFG_IW-1:0] {
        REG_SPRING_K,
        REG_DAMPER_C,
        REG_REST_LENGTH,
        REG_ANCHOR_X,
        REG_ANCHOR_Y,
        REG_ANCHOR_Z,
        REG_VERTICAL_GAIN,
        REG_ENABLED
    } cfg_reg_t;

    typedef struct packed {
        logic                body_present;
        logic signed [W-1:0] pos_x;
        logic signed [W-1:0] pos_y;
        logic signed [W-1:0] pos_z;
        logic signed [W-1:0] vel_x;
        logic signed [W-1:0] vel_y;
        logic signed [W-1:0] vel_z;
    } sample_t;

    typedef struct packed {
        logic                force_applied;
        logic signed [W-1:0] force_x;
        logic signed [W-1:0] force_y;
        logic signed [W-1:0] force_z;
    } result_t;

    typedef struct packed {
        logic [W-2:0] spring_k;
        logic [W-2:0] damper_c;
        logic [W-2:0] vertical_gain;
    } coef_t;

    typedef struct packed {
        logic                         live;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][DW-1:0]     dmag;
        logic [LANES-1:0][W-1:0]      vel;
    } sqrt_side_t;

    typedef struct packed {
        logic                         live;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][W-1:0]      vel;
        logic [W-1:0]                 x;
    } div_side_t;

    // Shift a product magnitude right by F (toward zero), apply sign, clamp.
    function automatic logic [W-1:0] shr_sat(input logic neg, input logic [PW-1:0] p);
        logic [PW-1:0] s;
        logic [W-1:0]  r;
        s = p >> F;
        if (neg) begin
            if ((|s[PW-1:W]) || (s[W-1] && (|s[W-2:0])))
                r = SMIN;
            else
                r = -s[W-1:0];
        end
        else begin
            if (|s[PW-1:W-1])
                r = SMAX;
            else
                r = s[W-1:0];
        end
        return r;
    endfunction

    function automatic logic [W-1:0] fmul(input logic signed [W:0] a,
                                          input logic signed [W:0] b);
        logic [W:0] ma;
        logic [W:0] mb;
        ma = a[W] ? -a : a;
        mb = b[W] ? -b : b;
        return shr_sat(a[W] ^ b[W], ma * mb);
    endfunction

endpackage

### hw/rtl/spring_damper_rope_force.sv
// Rope force toward a configured anchor, signed Q16.16 throughout. Each sample
// gives one result, in order. A new sample is taken every cycle while
// sample_stall is low. The square root produces one root bit per stage and the
// direction divider one quotient bit per stage, for three lanes.
// The whole pipeline holds while a result waits at the output with stall high;
// an empty output register lets it advance. A skipped sample (disabled, no
// body, distance at most 66 LSB, or slack rope) returns force_applied low and
// zero force. Write configuration only while no sample is in flight.
module spring_damper_rope_force
    import sdrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  sample_t           sample,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [W-1:0]      cfg_data
);

    logic [W-2:0] spring_k_reg;
    logic [W-2:0] damper_c_reg;
    logic [W-2:0] rest_length_reg;
    logic [W-1:0] anchor_x_reg;
    logic [W-1:0] anchor_y_reg;
    logic [W-1:0] anchor_z_reg;
    logic [W-2:0] vertical_gain_reg;
    logic         enabled_reg;

    logic adv;
    assign adv          = !result_valid || !result_stall;
    assign sample_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spring_k_reg      <= '0;
            damper_c_reg      <= '0;
            rest_length_reg   <= '0;
            anchor_x_reg      <= '0;
            anchor_y_reg      <= '0;
            anchor_z_reg      <= '0;
            vertical_gain_reg <= GAIN_RST;
            enabled_reg       <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SPRING_K:      spring_k_reg      <= cfg_data[W-2:0];
                REG_DAMPER_C:      damper_c_reg      <= cfg_data[W-2:0];
                REG_REST_LENGTH:   rest_length_reg   <= cfg_data[W-2:0];
                REG_ANCHOR_X:      anchor_x_reg      <= cfg_data;
                REG_ANCHOR_Y:      anchor_y_reg      <= cfg_data;
                REG_ANCHOR_Z:      anchor_z_reg      <= cfg_data;
                REG_VERTICAL_GAIN: vertical_gain_reg <= cfg_data[W-2:0];
                REG_ENABLED:       enabled_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // T0: offset from anchor
    logic                          t0_valid_reg;
    logic                          t0_live_reg;
    logic [LANES-1:0][DW-1:0]      t0_d_reg;
    logic [LANES-1:0][W-1:0]       t0_vel_reg;
    // T1: squares
    logic                          t1_valid_reg;
    logic [LANES-1:0][2*DW-1:0]    t1_sq_reg;
    sqrt_side_t                    t1_side_reg;
    // T2: radicand
    logic                          t2_valid_reg;
    logic [SQW-1:0]                t2_rad_reg;
    sqrt_side_t                    t2_side_reg;
    // T3: stretch and skip decision
    logic                          t3_valid_reg;
    logic [RTW-1:0]                t3_den_reg;
    logic [LANES-1:0][DW-1:0]      t3_num_reg;
    div_side_t                     t3_side_reg;

    logic [LANES-1:0][DW-1:0]      d_next;
    logic [LANES-1:0][DW-1:0]      dmag;
    logic [LANES-1:0]              dneg;
    logic [LANES-1:0][2*DW-1:0]    sq_next;

    logic                          sq_valid;
    logic [RTW-1:0]                rope_len;
    sqrt_side_t                    sq_side;
    logic [RTW-1:0]                stretch;
    logic [W-1:0]                  x_sat;
    logic                          ok;

    logic                          dv_valid;
    logic [LANES-1:0][QW-1:0]      dv_quo;
    div_side_t                     dv_side;
    coef_t                         coef;

    assign d_next[0] = {sample.pos_x[W-1], sample.pos_x} - {anchor_x_reg[W-1], anchor_x_reg};
    assign d_next[1] = {sample.pos_y[W-1], sample.pos_y} - {anchor_y_reg[W-1], anchor_y_reg};
    assign d_next[2] = {sample.pos_z[W-1], sample.pos_z} - {anchor_z_reg[W-1], anchor_z_reg};

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            dneg[l]    = t0_d_reg[l][DW-1];
            dmag[l]    = dneg[l] ? -t0_d_reg[l] : t0_d_reg[l];
            sq_next[l] = dmag[l] * dmag[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_valid_reg <= 1'b0;
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t0_valid_reg <= sample_valid;
            t1_valid_reg <= t0_valid_reg;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_live_reg   <= enabled_reg && sample.body_present;
            t0_d_reg      <= d_next;
            t0_vel_reg    <= {sample.vel_z, sample.vel_y, sample.vel_x};

            t1_sq_reg         <= sq_next;
            t1_side_reg.live  <= t0_live_reg;
            t1_side_reg.neg   <= dneg;
            t1_side_reg.dmag  <= dmag;
            t1_side_reg.vel   <= t0_vel_reg;

            t2_rad_reg  <= SQW'(t1_sq_reg[0]) + SQW'(t1_sq_reg[1]) + SQW'(t1_sq_reg[2]);
            t2_side_reg <= t1_side_reg;

            t3_den_reg       <= rope_len;
            t3_num_reg       <= sq_side.dmag;
            t3_side_reg.live <= ok;
            t3_side_reg.neg  <= sq_side.neg;
            t3_side_reg.vel  <= sq_side.vel;
            t3_side_reg.x    <= x_sat;
        end
    end

    sdrf_sqrt #(
        .SIDE_W ($bits(sqrt_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .src_valid (t2_valid_reg),
        .src_rad   (t2_rad_reg),
        .src_side  (t2_side_reg),
        .dst_valid (sq_valid),
        .dst_root  (rope_len),
        .dst_side  (sq_side)
    );

    assign stretch = rope_len - RTW'(rest_length_reg);
    assign x_sat   = (|stretch[RTW-1:W-1]) ? SMAX : stretch[W-1:0];
    assign ok      = sq_side.live && (rope_len > DIST_EPS) && (rope_len > RTW'(rest_length_reg));

    sdrf_div #(
        .SIDE_W ($bits(div_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .src_valid (t3_valid_reg),
        .src_num   (t3_num_reg),
        .src_den   (t3_den_reg),
        .src_side  (t3_side_reg),
        .dst_valid (dv_valid),
        .dst_quo   (dv_quo),
        .dst_side  (dv_side)
    );

    assign coef.spring_k      = spring_k_reg;
    assign coef.damper_c      = damper_c_reg;
    assign coef.vertical_gain = vertical_gain_reg;

    sdrf_force u_force (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .coef      (coef),
        .src_valid (dv_valid),
        .src_quo   (dv_quo),
        .src_side  (dv_side),
        .dst_valid (result_valid),
        .dst       (result)
    );

endmodule

### hw/rtl/sdrf_sqrt.sv
module sdrf_sqrt
    import sdrf_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              src_valid,
    input  logic [SQW-1:0]    src_rad,
    input  logic [SIDE_W-1:0] src_side,
    output logic              dst_valid,
    output logic [RTW-1:0]    dst_root,
    output logic [SIDE_W-1:0] dst_side
);

    logic              valid_reg [RTW];
    logic [SQW-1:0]    rad_reg   [RTW];
    logic [RTW-1:0]    root_reg  [RTW];
    logic [RTW:0]      rem_reg   [RTW];
    logic [SIDE_W-1:0] side_reg  [RTW];

    // One root bit per stage, restoring digit recurrence.
    for (genvar s = 0; s < RTW; s++) begin : g_stage
        logic              vld_cur;
        logic [SQW-1:0]    rad_cur;
        logic [RTW-1:0]    root_cur;
        logic [RTW:0]      rem_cur;
        logic [SIDE_W-1:0] side_cur;
        logic [RTW+2:0]    rem_sh;
        logic [RTW+2:0]    trial;
        logic [RTW+2:0]    rem_dif;
        logic              fit;

        if (s == 0) begin : g_head
            assign vld_cur  = src_valid;
            assign rad_cur  = src_rad;
            assign root_cur = '0;
            assign rem_cur  = '0;
            assign side_cur = src_side;
        end
        else begin : g_body
            assign vld_cur  = valid_reg[s-1];
            assign rad_cur  = rad_reg[s-1];
            assign root_cur = root_reg[s-1];
            assign rem_cur  = rem_reg[s-1];
            assign side_cur = side_reg[s-1];
        end

        assign rem_sh  = {rem_cur, rad_cur[SQW-1 -: 2]};
        assign trial   = {1'b0, root_cur, 2'b01};
        assign rem_dif = rem_sh - trial;
        assign fit     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (adv)
                valid_reg[s] <= vld_cur;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[s]  <= {rad_cur[SQW-3:0], 2'b00};
                root_reg[s] <= {root_cur[RTW-2:0], fit};
                rem_reg[s]  <= fit ? rem_dif[RTW:0] : rem_sh[RTW:0];
                side_reg[s] <= side_cur;
            end
        end
    end

    assign dst_valid = valid_reg[RTW-1];
    assign dst_root  = root_reg[RTW-1];
    assign dst_side  = side_reg[RTW-1];

endmodule

### hw/rtl/sdrf_div.sv
module sdrf_div
    import sdrf_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     src_valid,
    input  logic [LANES-1:0][DW-1:0] src_num,
    input  logic [RTW-1:0]           src_den,
    input  logic [SIDE_W-1:0]        src_side,
    output logic                     dst_valid,
    output logic [LANES-1:0][QW-1:0] dst_quo,
    output logic [SIDE_W-1:0]        dst_side
);

    logic                      valid_reg [QW];
    logic [RTW-1:0]            den_reg   [QW];
    logic [LANES-1:0][RTW-1:0] rem_reg   [QW];
    logic [LANES-1:0][QW-1:0]  quo_reg   [QW];
    logic [SIDE_W-1:0]         side_reg  [QW];

    // Numerator never exceeds the divisor, so the quotient has QW bits and
    // the low F dividend bits are zero: first stage compares, rest shift in 0.
    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic                      vld_cur;
        logic [RTW-1:0]            den_cur;
        logic [LANES-1:0][RTW:0]   t_cur;
        logic [LANES-1:0][QW-1:0]  quo_cur;
        logic [SIDE_W-1:0]         side_cur;

        if (s == 0) begin : g_head
            assign vld_cur  = src_valid;
            assign den_cur  = src_den;
            assign quo_cur  = '0;
            assign side_cur = src_side;
            for (genvar l = 0; l < LANES; l++) begin : g_ln
                assign t_cur[l] = (RTW+1)'(src_num[l]);
            end
        end
        else begin : g_body
            assign vld_cur  = valid_reg[s-1];
            assign den_cur  = den_reg[s-1];
            assign quo_cur  = quo_reg[s-1];
            assign side_cur = side_reg[s-1];
            for (genvar l = 0; l < LANES; l++) begin : g_ln
                assign t_cur[l] = {rem_reg[s-1][l], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (adv)
                valid_reg[s] <= vld_cur;
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic         fit;
            logic [RTW:0] dif;

            assign fit = t_cur[l] >= {1'b0, den_cur};
            assign dif = t_cur[l] - {1'b0, den_cur};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[s][l] <= fit ? dif[RTW-1:0] : t_cur[l][RTW-1:0];
                    quo_reg[s][l] <= {quo_cur[l][QW-2:0], fit};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[s]  <= den_cur;
                side_reg[s] <= side_cur;
            end
        end
    end

    assign dst_valid = valid_reg[QW-1];
    assign dst_quo   = quo_reg[QW-1];
    assign dst_side  = side_reg[QW-1];

endmodule

### hw/rtl/sdrf_force.sv
module sdrf_force
    import sdrf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  coef_t                    coef,
    input  logic                     src_valid,
    input  logic [LANES-1:0][QW-1:0] src_quo,
    input  div_side_t                src_side,
    output logic                     dst_valid,
    output result_t                  dst
);

    // stage 1: direction, velocity products, spring term
    logic                          s1_valid_reg;
    logic                          s1_live_reg;
    logic [LANES-1:0][NW-1:0]      s1_n_reg;
    logic [LANES-1:0][W+NW-1:0]    s1_prod_reg;
    logic [W-1:0]                  s1_kx_reg;
    // stage 2: velocity along rope
    logic                          s2_valid_reg;
    logic                          s2_live_reg;
    logic [LANES-1:0][NW-1:0]      s2_n_reg;
    logic [W-1:0]                  s2_vn_reg;
    logic [W-1:0]                  s2_kx_reg;
    // stage 3: damper term
    logic                          s3_valid_reg;
    logic                          s3_live_reg;
    logic [LANES-1:0][NW-1:0]      s3_n_reg;
    logic [W-1:0]                  s3_kx_reg;
    logic [W-1:0]                  s3_cv_reg;
    // stage 4: magnitude
    logic                          s4_valid_reg;
    logic                          s4_live_reg;
    logic [LANES-1:0][NW-1:0]      s4_n_reg;
    logic [W-1:0]                  s4_m_reg;
    // stage 5: components
    logic                          s5_valid_reg;
    logic                          s5_live_reg;
    logic [LANES-1:0][W-1:0]       s5_f_reg;
    // output
    logic                          out_valid_reg;
    result_t                       out_reg;

    logic [LANES-1:0][NW-1:0]      n_next;
    logic [LANES-1:0][W+NW-1:0]    prod_next;
    logic signed [VNW-1:0]         vsum;
    logic [VNW-1:0]                vabs;
    logic signed [W+1:0]           mdif;
    logic [W-1:0]                  m_next;
    logic [LANES-1:0][W-1:0]       f_next;
    logic [W-1:0]                  fy_next;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            n_next[l]    = src_side.neg[l] ? -NW'(src_quo[l]) : NW'(src_quo[l]);
            prod_next[l] = $signed(src_side.vel[l]) * $signed(n_next[l]);
        end
    end

    assign vsum = $signed(VNW'($signed(s1_prod_reg[0]))) + $signed(VNW'($signed(s1_prod_reg[1])))
                + $signed(VNW'($signed(s1_prod_reg[2])));
    assign vabs = vsum[VNW-1] ? -vsum : vsum;

    assign mdif = -$signed({{2{s3_kx_reg[W-1]}}, s3_kx_reg})
                - $signed({{2{s3_cv_reg[W-1]}}, s3_cv_reg});

    always_comb
    begin
        if (mdif[W+1:W-1] == 3'b000 || mdif[W+1:W-1] == 3'b111)
            m_next = mdif[W-1:0];
        else
            m_next = mdif[W+1] ? SMIN : SMAX;
        for (int l = 0; l < LANES; l++)
            f_next[l] = fmul({s4_m_reg[W-1], s4_m_reg},
                             (W+1)'($signed(s4_n_reg[l])));
    end

    assign fy_next = fmul({s5_f_reg[1][W-1], s5_f_reg[1]}, {2'b00, coef.vertical_gain});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= src_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_live_reg <= src_side.live;
            s1_n_reg    <= n_next;
            s1_prod_reg <= prod_next;
            s1_kx_reg   <= fmul({2'b00, coef.spring_k}, {1'b0, src_side.x});

            s2_live_reg <= s1_live_reg;
            s2_n_reg    <= s1_n_reg;
            s2_vn_reg   <= shr_sat(vsum[VNW-1], PW'(vabs));
            s2_kx_reg   <= s1_kx_reg;

            s3_live_reg <= s2_live_reg;
            s3_n_reg    <= s2_n_reg;
            s3_kx_reg   <= s2_kx_reg;
            s3_cv_reg   <= fmul({2'b00, coef.damper_c}, {s2_vn_reg[W-1], s2_vn_reg});

            s4_live_reg <= s3_live_reg;
            s4_n_reg    <= s3_n_reg;
            s4_m_reg    <= m_next;

            s5_live_reg <= s4_live_reg;
            s5_f_reg    <= f_next;

            // skipped items give zero force
            out_reg.force_applied <= s5_live_reg;
            out_reg.force_x       <= s5_live_reg ? s5_f_reg[0] : '0;
            out_reg.force_y       <= s5_live_reg ? fy_next : '0;
            out_reg.force_z       <= s5_live_reg ? s5_f_reg[2] : '0;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst       = out_reg;

endmodule

### verif/rope_force_checker.sv
`timescale 1ns / 100ps

module rope_force_checker
    import sdrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    input  logic              sample_stall,
    input  sample_t           sample,
    input  logic              result_valid,
    input  logic              result_stall,
    input  result_t           result,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [W-1:0]      cfg_data,
    output int                fail_count,
    output int                pending_count,
    output int                applied_count,
    output int                skipped_count
);

    localparam longint WMAX = 64'sh7FFF_FFFF;
    localparam longint WMIN = -64'sh8000_0000;

    logic [30:0]  k_q, c_q, rest_q, gain_q;
    logic signed [31:0] ax_q, ay_q, az_q;
    logic         en_q;
    result_t      force_queue[$];

    function automatic longint clamp_word(input longint v);
        if (v > WMAX)
            return WMAX;
        if (v < WMIN)
            return WMIN;
        return v;
    endfunction

    function automatic longint abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = (abs64(a) * abs64(b)) >>> F;
        return clamp_word(((a < 0) != (b < 0)) ? -p : p);
    endfunction

    // floor root of a radicand below 2^68
    function automatic longint floor_root(input logic [67:0] r);
        logic [67:0] lo, hi, mid;
        lo = 0;
        hi = 68'd1 << 34;
        while (hi - lo > 1) begin
            mid = lo + ((hi - lo) >> 1);
            if (mid * mid <= r)
                lo = mid;
            else
                hi = mid;
        end
        return longint'(lo);
    endfunction

    function automatic result_t rope_force(input sample_t s);
        result_t     o;
        longint      d[3], v[3], n[3], f[3];
        logic [67:0] rad;
        longint      rope_len, x, vn, t, q, m;
        o = '0;
        if (!en_q || !s.body_present)
            return o;
        d[0] = longint'(s.pos_x) - longint'(ax_q);
        d[1] = longint'(s.pos_y) - longint'(ay_q);
        d[2] = longint'(s.pos_z) - longint'(az_q);
        v[0] = s.vel_x;
        v[1] = s.vel_y;
        v[2] = s.vel_z;
        rad = 0;
        for (int i = 0; i < 3; i++)
            rad += 68'(abs64(d[i])) * 68'(abs64(d[i]));
        rope_len = floor_root(rad);
        if (rope_len <= longint'(DIST_EPS))
            return o;
        x = rope_len - longint'(rest_q);
        if (x <= 0)
            return o;
        x = clamp_word(x);
        vn = 0;
        for (int i = 0; i < 3; i++)
        begin
            q = (abs64(d[i]) << F) / rope_len;
            n[i] = (d[i] < 0) ? -q : q;
            vn += v[i] * n[i];
        end
        t = abs64(vn) >>> F;
        vn = clamp_word((vn < 0) ? -t : t);
        m = clamp_word(-qmul(longint'(k_q), x) - qmul(longint'(c_q), vn));
        for (int i = 0; i < 3; i++)
            f[i] = qmul(m, n[i]);
        f[1] = qmul(f[1], longint'(gain_q));
        o.force_applied = 1'b1;
        o.force_x = f[0][31:0];
        o.force_y = f[1][31:0];
        o.force_z = f[2][31:0];
        return o;
    endfunction

    assign pending_count = force_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            k_q <= '0; c_q <= '0; rest_q <= '0;
            ax_q <= '0; ay_q <= '0; az_q <= '0;
            gain_q <= GAIN_RST;
            en_q <= 1'b1;
            fail_count <= 0;
            applied_count <= 0;
            skipped_count <= 0;
            force_queue.delete();
        end
        else
        begin
            if (sample_valid && !sample_stall)
                force_queue.push_back(rope_force(sample));
            if (result_valid && !result_stall)
            begin
                if (force_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h", result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = force_queue.pop_front();
                    if (want.force_applied) applied_count <= applied_count + 1;
                    else skipped_count <= skipped_count + 1;
                    if (want.force_applied !== result.force_applied
                        || want.force_x !== result.force_x
                        || want.force_y !== result.force_y
                        || want.force_z !== result.force_z)
                    begin
                        if (fail_count < 10)
                            $display("force mismatch: expected %b %h %h %h, got %b %h %h %h",
                                     want.force_applied, want.force_x, want.force_y,
                                     want.force_z, result.force_applied, result.force_x,
                                     result.force_y, result.force_z);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SPRING_K:      k_q <= cfg_data[30:0];
                    REG_DAMPER_C:      c_q <= cfg_data[30:0];
                    REG_REST_LENGTH:   rest_q <= cfg_data[30:0];
                    REG_ANCHOR_X:      ax_q <= cfg_data;
                    REG_ANCHOR_Y:      ay_q <= cfg_data;
                    REG_ANCHOR_Z:      az_q <= cfg_data;
                    REG_VERTICAL_GAIN: gain_q <= cfg_data[30:0];
                    REG_ENABLED:       en_q <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### verif/tb_spring_damper_rope_force.sv
`timescale 1ns / 100ps

module tb_spring_damper_rope_force;
    import sdrf_pkg::*;

    localparam int LATENCY = 61;
    localparam int WATCHDOG = 20000;

    logic              clk;
    logic              rst_n;
    logic              sample_valid;
    logic              sample_stall;
    sample_t           sample;
    logic              result_valid;
    logic              result_stall;
    result_t           result;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [W-1:0]      cfg_data;
    int                fail_count, pending_count, applied_count, skipped_count;
    int                send_idle_pct, recv_stall_pct;
    int                quiet_cycles;
    int                sent;

    spring_damper_rope_force u_dut (.*);

    rope_force_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stall, random per cycle
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("watchdog expired, %0d items pending", pending_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [W-1:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        while (pending_count != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    // hold the item until accepted
    task automatic send(input sample_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid = 1'b0;
            @(negedge clk);
        end
        sample_valid = 1'b1;
        sample = s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        @(negedge clk);
        sample_valid = 1'b0;
        sent++;
    endtask

    function automatic logic [31:0] rand_word(input logic [31:0] anchor);
        case ($urandom_range(5))
            0: return $urandom;
            1: return anchor + $urandom_range(200) - 100;
            2: return anchor + ($urandom_range(8) << 16) - (4 << 16);
            3: return anchor + ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
            4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return anchor + ($urandom & 32'h0FFF_FFFF) - 32'h0800_0000;
        endcase
    endfunction

    task automatic send_random(input logic [31:0] ax, input logic [31:0] ay,
                               input logic [31:0] az);
        sample_t s;
        s.body_present = ($urandom_range(9) != 0);
        s.pos_x = rand_word(ax);
        s.pos_y = rand_word(ay);
        s.pos_z = rand_word(az);
        s.vel_x = ($urandom_range(3) == 0) ? $urandom : ($urandom & 32'h000F_FFFF) - 32'h0008_0000;
        s.vel_y = ($urandom_range(3) == 0) ? $urandom : ($urandom & 32'h000F_FFFF) - 32'h0008_0000;
        s.vel_z = ($urandom_range(3) == 0) ? $urandom : ($urandom & 32'h000F_FFFF) - 32'h0008_0000;
        send(s);
    endtask

    task automatic random_config(output logic [31:0] ax, output logic [31:0] ay,
                                 output logic [31:0] az);
        ax = ($urandom_range(3) == 0) ? $urandom : ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
        ay = ($urandom_range(3) == 0) ? $urandom : ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
        az = ($urandom_range(3) == 0) ? $urandom : ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
        write_reg(REG_SPRING_K, ($urandom_range(3) == 0) ? 32'h7FFF_FFFF : $urandom_range(32'h0040_0000));
        write_reg(REG_DAMPER_C, ($urandom_range(3) == 0) ? 32'h7FFF_FFFF : $urandom_range(32'h0004_0000));
        write_reg(REG_REST_LENGTH, ($urandom_range(4) == 0) ? 32'h7FFF_FFFF : $urandom_range(32'h0003_0000));
        write_reg(REG_ANCHOR_X, ax);
        write_reg(REG_ANCHOR_Y, ay);
        write_reg(REG_ANCHOR_Z, az);
        write_reg(REG_VERTICAL_GAIN, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0003_0000));
        write_reg(REG_ENABLED, 32'($urandom_range(7) != 0));
    endtask

    initial
    begin
        logic [31:0] ax, ay, az;
        sample_t s;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        result_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 24;
        recv_stall_pct = 71;
        quiet_cycles = 0;
        sent = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset config first, then extremes
        s = '0;
        s.body_present = 1'b1;
        s.pos_x = 32'h0001_0000;
        s.vel_x = 32'h0000_8000;
        send(s);
        s.pos_x = 32'd66;
        send(s);
        s.pos_x = 32'd67;
        send(s);
        s.body_present = 1'b0;
        send(s);
        drain();
        write_reg(REG_SPRING_K, 32'h0002_0000);
        write_reg(REG_DAMPER_C, 32'h0000_8000);
        write_reg(REG_REST_LENGTH, 32'h0001_0000);
        write_reg(REG_VERTICAL_GAIN, 32'(GAIN_RST));
        s.body_present = 1'b1;
        s.pos_x = 32'h0000_8000;
        send(s);
        s.pos_x = 32'h0001_0000;
        send(s);
        s.pos_x = 32'h0003_0000; s.pos_y = 32'hFFFC_0000; s.pos_z = 32'h0001_0000;
        s.vel_x = 32'h8000_0000; s.vel_y = 32'h7FFF_FFFF; s.vel_z = 32'hFFFF_FFFF;
        send(s);
        s.pos_x = 32'h7FFF_FFFF; s.pos_y = 32'h8000_0000; s.pos_z = 32'h7FFF_FFFF;
        send(s);
        s.pos_x = 32'h8000_0000; s.pos_y = 32'h8000_0000; s.pos_z = 32'h8000_0000;
        s.vel_x = 32'h7FFF_FFFF; s.vel_y = 32'h8000_0000; s.vel_z = 32'h0;
        send(s);
        drain();
        write_reg(REG_SPRING_K, 32'h7FFF_FFFF);
        write_reg(REG_DAMPER_C, 32'h7FFF_FFFF);
        write_reg(REG_REST_LENGTH, 32'h0);
        write_reg(REG_ANCHOR_X, 32'h7FFF_FFFF);
        write_reg(REG_ANCHOR_Y, 32'h8000_0000);
        write_reg(REG_ANCHOR_Z, 32'h7FFF_FFFF);
        write_reg(REG_VERTICAL_GAIN, 32'h7FFF_FFFF);
        send(s);
        s.pos_x = 32'h7FFF_0000; s.pos_y = 32'h8001_0000; s.pos_z = 32'h7FFF_FFFF;
        send(s);
        s.vel_x = 32'hFFFF_FFFF; s.vel_y = 32'hFFFF_FFFF; s.vel_z = 32'hFFFF_FFFF;
        send(s);
        drain();
        write_reg(REG_REST_LENGTH, 32'h7FFF_FFFF);
        send(s);
        drain();
        write_reg(REG_ENABLED, 32'h0);
        write_reg(REG_VERTICAL_GAIN, 32'h0);
        write_reg(REG_REST_LENGTH, 32'h0);
        send(s);
        drain();
        write_reg(REG_ENABLED, 32'h1);
        send(s);
        drain();

        // random phases: receiver mostly stalls, then sender mostly idles, then neither
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 71 : 0;
            recv_stall_pct = (phase == 0) ? 71 : (phase == 1) ? 24 : 0;
            for (int blk = 0; blk < 6; blk++)
            begin
                random_config(ax, ay, az);
                repeat (40)
                    send_random(ax, ay, az);
                drain();
            end
        end

        drain();
        $display("%0d items sent over several config sets: %0d forces, %0d skipped",
                 sent, applied_count, skipped_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
